[rtl/core/tlpc_pkg.sv]
package tlpc_pkg;

	// field widths
	localparam int unsigned LEVEL_W    = 7;
	localparam int unsigned DIST_W     = 16;
	localparam int unsigned AGE_W      = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned BAND_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// distance to level line: 100 % at full distance, 0 % at empty distance
	localparam int unsigned DIST_FULL   = 17;
	localparam int unsigned DIST_EMPTY  = 81;
	localparam int unsigned LEVEL_SPAN  = 100;
	// span is a power of two, so the divide is a shift
	localparam int unsigned LEVEL_SHIFT = $clog2(DIST_EMPTY - DIST_FULL);
	localparam int unsigned OFFS_W      = LEVEL_SHIFT;
	localparam int unsigned PROD_W      = OFFS_W + LEVEL_W;

	localparam logic [DIST_W-1:0] NO_READING = '1;
	localparam logic [AGE_W-1:0]  AGE_MAX    = '1;

	// register reset values
	localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 7'd30;
	localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST  = 7'd100;
	localparam logic [LEVEL_W-1:0] BLOCK_LEVEL_RST = 7'd95;
	localparam logic [BAND_W-1:0]  DEAD_BAND_RST   = 8'd3;
	localparam logic [AGE_W-1:0]   HOLD_MS_RST     = 16'd3000;
	localparam logic [AGE_W-1:0]   LOSS_MS_RST     = 16'd30000;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_DIST   = 2'd1,
		MODE_HBEAT  = 2'd2,
		MODE_MANUAL = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LEVEL = 3'd0,
		REG_STOP_LEVEL  = 3'd1,
		REG_BLOCK_LEVEL = 3'd2,
		REG_DEAD_BAND   = 3'd3,
		REG_HOLD_MS     = 3'd4,
		REG_LOSS_MS     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		mode_t             mode;
		logic [DIST_W-1:0] distance;
		logic              heartbeat_value;
		logic              bypass;
	} in_item_t;

	typedef struct packed {
		logic               pump_on;
		logic [LEVEL_W-1:0] level_percent;
		logic               heartbeat_ok;
		logic [CNT_W-1:0]   run_count;
		logic               pump_started;
		logic               pump_stopped;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

endpackage

[rtl/core/tlpc_in_if.sv]
interface tlpc_in_if
	import tlpc_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tlpc_out_if.sv]
interface tlpc_out_if
	import tlpc_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tlpc_cfg_if.sv]
interface tlpc_cfg_if
	import tlpc_pkg::*;
();
	logic       valid;
	logic       ready;
	cfg_write_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tlpc_level.sv]
module tlpc_level
	import tlpc_pkg::*;
(
	input  logic [DIST_W-1:0]  distance,
	output logic [LEVEL_W-1:0] level
);

	logic [DIST_W-1:0] diff;
	logic [OFFS_W-1:0] offs;
	logic [PROD_W-1:0] prod;

	// offset from full distance is below the span inside the sloped region
	assign diff = distance - DIST_W'(DIST_FULL);
	assign offs = diff[OFFS_W-1:0];
	assign prod = PROD_W'(offs) * PROD_W'(LEVEL_SPAN);

	// clamp at both ends, straight line between
	always_comb begin
		if (distance <= DIST_W'(DIST_FULL)) begin
			level = LEVEL_W'(LEVEL_SPAN);
		end else if (distance >= DIST_W'(DIST_EMPTY)) begin
			level = '0;
		end else begin
			level = LEVEL_W'(LEVEL_SPAN) - prod[PROD_W-1:LEVEL_SHIFT];
		end
	end

endmodule

[rtl/core/tank_level_pump_control.sv]
// Tank level pump controller. Each transfer on item is a 1 ms tick, a distance
// report, a heartbeat report or a manual toggle, and produces exactly one transfer
// on result with the pump state, level percent, heartbeat flag, start count and
// the started/stopped flags for that item. The block takes one item per clock
// cycle while the result is not stalled: items land in an input register, and one
// pass of compare logic against the controller state (distance, heartbeat age,
// pump) writes the state and the result register in the same cycle. A stalled
// result holds the pipeline; while the result waits, the input register takes an
// item only if it is empty. Configuration writes on cfg are always taken and must
// be made while no item is in flight; writes to unknown indexes are dropped.
module tank_level_pump_control
	import tlpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tlpc_in_if.sink    item,
	tlpc_out_if.source result,
	tlpc_cfg_if.sink   cfg
);

	// configuration registers
	logic [LEVEL_W-1:0] start_level_q;
	logic [LEVEL_W-1:0] stop_level_q;
	logic [LEVEL_W-1:0] block_level_q;
	logic [BAND_W-1:0]  dead_band_q;
	logic [AGE_W-1:0]   hold_ms_q;
	logic [AGE_W-1:0]   loss_ms_q;

	// controller state
	logic [DIST_W-1:0] dist_q;
	logic              hb_flag_q;
	logic [AGE_W-1:0]  hb_age_q;
	logic              running_q;
	logic [CNT_W-1:0]  run_cnt_q;

	// pipeline
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;
	logic      fire_s1;

	// next-state logic
	logic [DIST_W-1:0]  dist_diff;
	logic               in_band;
	logic [DIST_W-1:0]  dist_c;
	logic [LEVEL_W-1:0] level_c;
	logic               flag_ev;
	logic [AGE_W-1:0]   age_ev;
	logic               hb_clear;
	logic               flag_c;
	logic [AGE_W-1:0]   age_c;
	logic               block_ok;
	logic               start_m;
	logic               stop_m;
	logic               run_m;
	logic               start_a;
	logic               run_a;
	logic               stop_full;
	logic               run_f;
	logic               stop_loss;
	logic               run_c;
	logic               started_c;
	logic               stopped_c;
	logic [CNT_W-1:0]   cnt_c;

	// handshakes
	assign fire_s1      = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready   = !valid_s1 || fire_s1;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= START_LEVEL_RST;
			stop_level_q  <= STOP_LEVEL_RST;
			block_level_q <= BLOCK_LEVEL_RST;
			dead_band_q   <= DEAD_BAND_RST;
			hold_ms_q     <= HOLD_MS_RST;
			loss_ms_q     <= LOSS_MS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.payload.index)
				REG_START_LEVEL: start_level_q <= cfg.payload.data[LEVEL_W-1:0];
				REG_STOP_LEVEL:  stop_level_q  <= cfg.payload.data[LEVEL_W-1:0];
				REG_BLOCK_LEVEL: block_level_q <= cfg.payload.data[LEVEL_W-1:0];
				REG_DEAD_BAND:   dead_band_q   <= cfg.payload.data[BAND_W-1:0];
				REG_HOLD_MS:     hold_ms_q     <= cfg.payload.data[AGE_W-1:0];
				REG_LOSS_MS:     loss_ms_q     <= cfg.payload.data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	// distance report with dead band
	assign dist_diff = (item_s1.distance > dist_q) ? item_s1.distance - dist_q
	                                               : dist_q - item_s1.distance;
	assign in_band   = (dist_diff <= DIST_W'(dead_band_q)) && (dist_q != NO_READING);
	assign dist_c    = (item_s1.mode == MODE_DIST && !in_band) ? item_s1.distance : dist_q;

	tlpc_level u_level (
		.distance (dist_c),
		.level    (level_c)
	);

	// heartbeat event, then hold-time clear
	always_comb begin
		flag_ev = hb_flag_q;
		age_ev  = hb_age_q;
		unique case (item_s1.mode)
			MODE_TICK: begin
				if (hb_age_q != AGE_MAX) begin
					age_ev = hb_age_q + AGE_W'(1);
				end
			end
			MODE_HBEAT: begin
				flag_ev = item_s1.heartbeat_value;
				age_ev  = '0;
			end
			MODE_DIST, MODE_MANUAL: ;
		endcase
	end

	assign hb_clear = flag_ev && (age_ev >= hold_ms_q);
	assign flag_c   = flag_ev && !hb_clear;
	assign age_c    = hb_clear ? '0 : age_ev;

	// manual toggle; a start is refused above the block level unless bypassed
	assign block_ok = (level_c <= block_level_q) || item_s1.bypass;
	assign start_m  = (item_s1.mode == MODE_MANUAL) && !running_q && block_ok;
	assign stop_m   = (item_s1.mode == MODE_MANUAL) && running_q;
	assign run_m    = start_m || (running_q && !stop_m);

	// automatic control in order: start, stop at full, stop on heartbeat loss
	assign start_a   = !item_s1.bypass && (level_c <= start_level_q) && flag_c && !run_m
	                   && (level_c <= block_level_q);
	assign run_a     = run_m || start_a;
	assign stop_full = !item_s1.bypass && (level_c >= stop_level_q) && flag_c && run_a;
	assign run_f     = run_a && !stop_full;
	assign stop_loss = !item_s1.bypass && !flag_c && (age_c >= loss_ms_q) && run_f;
	assign run_c     = run_f && !stop_loss;

	// at most one start per item
	assign started_c = start_m || start_a;
	assign stopped_c = stop_m || stop_full || stop_loss;
	assign cnt_c     = run_cnt_q + CNT_W'(started_c);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q    <= NO_READING;
			hb_flag_q <= 1'b0;
			hb_age_q  <= '0;
			running_q <= 1'b0;
			run_cnt_q <= '0;
		end else if (fire_s1) begin
			dist_q    <= dist_c;
			hb_flag_q <= flag_c;
			hb_age_q  <= age_c;
			running_q <= run_c;
			run_cnt_q <= cnt_c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q.pump_on       <= run_c;
			out_q.level_percent <= level_c;
			out_q.heartbeat_ok  <= flag_c;
			out_q.run_count     <= cnt_c;
			out_q.pump_started  <= started_c;
			out_q.pump_stopped  <= stopped_c;
		end
	end

`ifndef SYNTHESIS
	// a start with no stop leaves the pump running
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.pump_started && !result.payload.pump_stopped
		|-> result.payload.pump_on)
		else $error("pump started but reported off");

	// a stop with no start leaves the pump off
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.pump_stopped && !result.payload.pump_started
		|-> !result.payload.pump_on)
		else $error("pump stopped but reported on");

	// level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.payload.level_percent <= LEVEL_W'(LEVEL_SPAN))
		else $error("level above full scale");

	// start count moves by one exactly on a start
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> run_cnt_q == $past(run_cnt_q) + CNT_W'($past(started_c)))
		else $error("start count out of step");
`endif

endmodule

[tb/sv/tank_pump_checker.sv]
`timescale 1ns / 100ps

// Watches the item, result and configuration channels of the pump controller,
// keeps its own copy of the controller state and checks every result transfer.
module tank_pump_checker
	import tlpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_ready,
	input  in_item_t   item_payload,
	input  logic       result_valid,
	input  logic       result_ready,
	input  out_item_t  result_payload,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  cfg_write_t cfg_payload,
	output int         fail_count,
	output int         pending
);

	localparam int REPORT_LIMIT = 10;

	// shadow registers
	logic [LEVEL_W-1:0] start_lvl;
	logic [LEVEL_W-1:0] stop_lvl;
	logic [LEVEL_W-1:0] block_lvl;
	logic [BAND_W-1:0]  band;
	logic [AGE_W-1:0]   hold_ms;
	logic [AGE_W-1:0]   loss_ms;

	// controller state
	logic [DIST_W-1:0] stored_dist;
	logic              hb_flag;
	logic [AGE_W-1:0]  hb_age;
	logic              running;
	logic [CNT_W-1:0]  starts;

	out_item_t expected_status[$];
	out_item_t want;
	out_item_t next_status;

	function automatic logic [LEVEL_W-1:0] level_from_distance(logic [DIST_W-1:0] d);
		if (d <= DIST_FULL)
			return LEVEL_W'(LEVEL_SPAN);
		if (d >= DIST_EMPTY)
			return '0;
		return LEVEL_W'(LEVEL_SPAN - ((d - DIST_FULL) * LEVEL_SPAN) / (DIST_EMPTY - DIST_FULL));
	endfunction

	function automatic string status_text(out_item_t s);
		return $sformatf("pump_on=%0b level=%0d hb_ok=%0b runs=%0d started=%0b stopped=%0b",
			s.pump_on, s.level_percent, s.heartbeat_ok, s.run_count,
			s.pump_started, s.pump_stopped);
	endfunction

	// a start is refused above the block level unless bypassed
	task automatic start_pump(input logic byp, inout logic started);
		if (level_from_distance(stored_dist) > block_lvl && !byp)
			return;
		running = 1'b1;
		starts = starts + CNT_W'(1);
		started = 1'b1;
	endtask

	task automatic halt_pump(inout logic stopped);
		running = 1'b0;
		stopped = 1'b1;
	endtask

	// one event against the controller state, in the block's order:
	// event, heartbeat hold, manual toggle, automatic control
	task automatic advance_controller(input in_item_t it, output out_item_t r);
		int unsigned diff;
		logic [LEVEL_W-1:0] lvl;
		logic started;
		logic stopped;
		started = 1'b0;
		stopped = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				if (hb_age != AGE_MAX)
					hb_age = hb_age + AGE_W'(1);
			end
			MODE_DIST: begin
				diff = (it.distance > stored_dist) ? it.distance - stored_dist
					: stored_dist - it.distance;
				if (!(diff <= band && stored_dist != NO_READING))
					stored_dist = it.distance;
			end
			MODE_HBEAT: begin
				hb_flag = it.heartbeat_value;
				hb_age = '0;
			end
			default: ;
		endcase
		if (hb_flag && hb_age >= hold_ms) begin
			hb_flag = 1'b0;
			hb_age = '0;
		end
		if (it.mode == MODE_MANUAL) begin
			if (running)
				halt_pump(stopped);
			else
				start_pump(it.bypass, started);
		end
		if (!it.bypass) begin
			lvl = level_from_distance(stored_dist);
			if (lvl <= start_lvl && hb_flag && !running)
				start_pump(1'b0, started);
			if (lvl >= stop_lvl && hb_flag && running)
				halt_pump(stopped);
			if (!hb_flag && hb_age >= loss_ms && running)
				halt_pump(stopped);
		end
		r.pump_on = running;
		r.level_percent = level_from_distance(stored_dist);
		r.heartbeat_ok = hb_flag;
		r.run_count = starts;
		r.pump_started = started;
		r.pump_stopped = stopped;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_lvl = START_LEVEL_RST;
			stop_lvl = STOP_LEVEL_RST;
			block_lvl = BLOCK_LEVEL_RST;
			band = DEAD_BAND_RST;
			hold_ms = HOLD_MS_RST;
			loss_ms = LOSS_MS_RST;
			stored_dist = NO_READING;
			hb_flag = 1'b0;
			hb_age = '0;
			running = 1'b0;
			starts = '0;
			expected_status.delete();
			pending = 0;
		end else begin
			// register write, masked to the register width
			if (cfg_valid && cfg_ready) begin
				case (cfg_payload.index)
					REG_START_LEVEL: start_lvl = cfg_payload.data[LEVEL_W-1:0];
					REG_STOP_LEVEL:  stop_lvl = cfg_payload.data[LEVEL_W-1:0];
					REG_BLOCK_LEVEL: block_lvl = cfg_payload.data[LEVEL_W-1:0];
					REG_DEAD_BAND:   band = cfg_payload.data[BAND_W-1:0];
					REG_HOLD_MS:     hold_ms = cfg_payload.data[AGE_W-1:0];
					REG_LOSS_MS:     loss_ms = cfg_payload.data[AGE_W-1:0];
					default: ;
				endcase
			end
			// result transfer against the oldest expectation
			if (result_valid && result_ready) begin
				if (expected_status.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with nothing expected: %s",
							$time, status_text(result_payload));
				end else begin
					want = expected_status.pop_front();
					if (result_payload.pump_on !== want.pump_on ||
						result_payload.level_percent !== want.level_percent ||
						result_payload.heartbeat_ok !== want.heartbeat_ok ||
						result_payload.run_count !== want.run_count ||
						result_payload.pump_started !== want.pump_started ||
						result_payload.pump_stopped !== want.pump_stopped) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
								status_text(want), status_text(result_payload));
					end
				end
			end
			// item transfer
			if (item_valid && item_ready) begin
				advance_controller(item_payload, next_status);
				expected_status.push_back(next_status);
			end
			pending = expected_status.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import tlpc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int RANDOM_PHASES   = 8;
	localparam int LONG_RUN        = 32;
	localparam int LOSS_RUN        = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	tlpc_in_if  item_ch ();
	tlpc_out_if result_ch ();
	tlpc_cfg_if cfg_ch ();

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit stall_en = 1'b1;
	bit gaps_on = 1'b1;
	logic [DIST_W-1:0] last_dist = NO_READING;
	logic [BAND_W-1:0] band_now = DEAD_BAND_RST;

	tank_level_pump_control uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tank_pump_checker status_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_ch.valid),
		.item_ready     (item_ch.ready),
		.item_payload   (item_ch.payload),
		.result_valid   (result_ch.valid),
		.result_ready   (result_ch.ready),
		.result_payload (result_ch.payload),
		.cfg_valid      (cfg_ch.valid),
		.cfg_ready      (cfg_ch.ready),
		.cfg_payload    (cfg_ch.payload),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic in_item_t ev(mode_t m, logic [DIST_W-1:0] d, logic h, logic b);
		in_item_t it;
		it.mode = m;
		it.distance = d;
		it.heartbeat_value = h;
		it.bypass = b;
		return it;
	endfunction

	// random event: mostly well-formed traffic, some raw noise
	function automatic in_item_t random_event();
		in_item_t it;
		int r;
		int span;
		if ($urandom_range(0, 9) == 0) begin
			it = $bits(in_item_t)'($urandom);
			return it;
		end
		r = $urandom_range(0, 99);
		it.distance = DIST_W'($urandom);
		it.heartbeat_value = ($urandom_range(0, 3) != 0);
		it.bypass = ($urandom_range(0, 7) == 0);
		if (r < 40) begin
			it.mode = MODE_TICK;
		end else if (r < 65) begin
			it.mode = MODE_DIST;
			case ($urandom_range(0, 9))
				0: it.distance = NO_READING;
				1: ;
				2, 3, 4: begin
					// around the dead band of the last report
					span = $urandom_range(0, int'(band_now) + 2);
					if ($urandom_range(0, 1))
						it.distance = last_dist + DIST_W'(span);
					else
						it.distance = last_dist - DIST_W'(span);
				end
				default: it.distance = DIST_W'($urandom_range(5, 95));
			endcase
		end else if (r < 85) begin
			it.mode = MODE_HBEAT;
		end else begin
			it.mode = MODE_MANUAL;
		end
		return it;
	endfunction

	// upper bits beyond the register width are don't-care
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
		logic [CFG_DATA_W-1:0] j;
		j = CFG_DATA_W'($urandom);
		if ($urandom_range(0, 1))
			return v;
		return (j << w) | v;
	endfunction

	// one item transfer, with an optional gap ahead of it
	task automatic push_item(in_item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (it.mode == MODE_DIST)
			last_dist = it.distance;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write_t w;
		w.index = idx;
		w.data = data;
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= w;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_regs(int start_lvl, int stop_lvl, int block_lvl, int band, int hold,
		int loss);
		write_reg(REG_START_LEVEL, with_junk(CFG_DATA_W'(start_lvl), LEVEL_W));
		write_reg(REG_STOP_LEVEL, with_junk(CFG_DATA_W'(stop_lvl), LEVEL_W));
		write_reg(REG_BLOCK_LEVEL, with_junk(CFG_DATA_W'(block_lvl), LEVEL_W));
		write_reg(REG_DEAD_BAND, with_junk(CFG_DATA_W'(band), BAND_W));
		write_reg(REG_HOLD_MS, CFG_DATA_W'(hold));
		write_reg(REG_LOSS_MS, CFG_DATA_W'(loss));
		// unknown index, dropped by the block
		write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
		band_now = BAND_W'(band);
	endtask

	// stop sending and let every expected result come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin
		result_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_en && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int p;
		int k;
		int lo;
		int hi;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		push_item(ev(MODE_TICK, 16'd0, 1'b0, 1'b0));      // no reading yet
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));    // manual start at level 0
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));    // manual stop
		push_item(ev(MODE_HBEAT, 16'd0, 1'b1, 1'b0));     // heartbeat, auto start
		push_item(ev(MODE_DIST, 16'd17, 1'b0, 1'b0));     // full tank, auto stop
		push_item(ev(MODE_DIST, 16'd18, 1'b0, 1'b0));     // inside dead band
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));    // refused above block level
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b1));    // bypassed start
		push_item(ev(MODE_TICK, 16'd0, 1'b0, 1'b0));      // auto stop at full
		push_item(ev(MODE_DIST, 16'd0, 1'b0, 1'b0));
		push_item(ev(MODE_DIST, 16'd81, 1'b0, 1'b0));     // empty, auto start
		push_item(ev(MODE_DIST, NO_READING, 1'b0, 1'b0)); // back to no reading
		push_item(ev(MODE_DIST, 16'd65532, 1'b0, 1'b0));  // taken, no reading before
		push_item(ev(MODE_DIST, 16'd49, 1'b0, 1'b0));     // mid level
		push_item(ev(MODE_HBEAT, 16'd0, 1'b0, 1'b0));     // heartbeat lost
		push_item(ev(MODE_DIST, 16'd53, 1'b0, 1'b0));     // just past the band
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b1));    // manual stop with bypass

		// zero hold and zero loss time
		drain();
		set_regs(START_LEVEL_RST, STOP_LEVEL_RST, BLOCK_LEVEL_RST, DEAD_BAND_RST, 0, 0);
		push_item(ev(MODE_HBEAT, 16'd0, 1'b1, 1'b0));     // cleared in the same item
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));    // start and loss stop together
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b1));
		push_item(ev(MODE_TICK, 16'd0, 1'b0, 1'b0));      // loss stop

		// back-to-back runs: repeated restarts, then heartbeat loss after a run of ticks
		drain();
		set_regs(100, 101, 127, 0, 16'hFFFF, LOSS_RUN);
		gaps_on = 1'b0;
		stall_en = 1'b0;
		push_item(ev(MODE_HBEAT, 16'd0, 1'b1, 1'b0));
		// each toggle stops the pump and auto start brings it back
		for (k = 0; k < LONG_RUN; k++)
			push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));
		push_item(ev(MODE_HBEAT, 16'd0, 1'b0, 1'b0));
		for (k = 0; k < LONG_RUN; k++)
			push_item(ev(MODE_TICK, 16'd0, 1'b0, 1'b0));
		push_item(ev(MODE_MANUAL, 16'd0, 1'b0, 1'b0));    // lost heartbeat stops it again

		// random phases under several settings
		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0: set_regs(0, 0, 0, 0, 0, 0);
				1: set_regs(127, 127, 127, 255, 16'hFFFF, 16'hFFFF);
				2: set_regs(START_LEVEL_RST, STOP_LEVEL_RST, BLOCK_LEVEL_RST, DEAD_BAND_RST,
					HOLD_MS_RST, LOSS_MS_RST);
				default: begin
					lo = $urandom_range(0, 100);
					hi = lo + $urandom_range(10, 70);
					if (hi > 100)
						hi = 100;
					if ($urandom_range(0, 3) == 0)
						hi = $urandom_range(0, 127);
					set_regs(lo, hi, $urandom_range(20, 127),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8),
						$urandom_range(1, 40), $urandom_range(1, 150));
				end
			endcase
			stall_en = ($urandom_range(0, 3) != 0);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				push_item(random_event());
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
